// File: design/uefa_pkg.sv
// ----------------------------------------------------------------------------
// uefa_pkg: shared types and helpers of the upwind edge flux accumulator
// Item formats, item kinds, reset constants and saturation functions.
// ----------------------------------------------------------------------------
package uefa_pkg;

  localparam int unsigned NODE_COUNT_DEF = 1024;
  localparam logic [31:0] TIME_STEP_RESET = 32'd65536;

  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_INTERIOR = 2'd1,
    KIND_BOUNDARY = 2'd2,
    KIND_FINAL    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [9:0]         node_a;
    logic [9:0]         node_b;
    logic signed [31:0] vel_u;
    logic signed [31:0] vel_v;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic [30:0]        edge_length;
    logic [30:0]        volume;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_node;
    logic signed [31:0] rhs_u;
    logic signed [31:0] rhs_v;
  } out_item_t;

  // Request from the sequencer to the serial divider.
  typedef struct packed {
    logic        start;
    logic [30:0] divisor;
    logic [30:0] rem;
    logic [31:0] low;
  } div_req_t;

  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -50'sd2147483648;
  localparam logic signed [49:0] S48_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] S48_MIN = -50'sd140737488355328;

  function automatic logic signed [49:0] ext48(input logic signed [47:0] x);
    return {{2{x[47]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7fffffff;
    else if (x < S32_MIN) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    logic signed [47:0] r;
    if (x > S48_MAX) r = {1'b0, {47{1'b1}}};
    else if (x < S48_MIN) r = {1'b1, {47{1'b0}}};
    else r = x[47:0];
    return r;
  endfunction

endpackage

// File: design/uefa_div.sv
// ----------------------------------------------------------------------------
// uefa_div: restoring serial divider
// Divides {rem, low} by divisor, one quotient bit per cycle, into a 32-bit quotient.
// The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module uefa_div
  import uefa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [30:0] rem_r;
  logic [30:0] dsr_r;
  logic [31:0] quo_r;
  logic [31:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[31]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= req.rem;
        dsr_r  <= req.divisor;
        quo_r  <= req.low;
      end else if (busy_r) begin
        // The remainder stays below the divisor, so 31 bits hold it.
        rem_r <= fits ? 31'(trial - {1'b0, dsr_r}) : trial[30:0];
        quo_r <= {quo_r[30:0], fits};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: design/upwind_edge_flux_accumulator_unit.sv
// ----------------------------------------------------------------------------
// upwind_edge_flux_accumulator_unit: first-order upwind convective flux
// Node store with velocity, volume and saturating 48-bit sums, updated by
// edge items and read out, scaled by time step over volume, by finalize.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_valid/in_ready; one transfer moves one in_item_t.
//   in_ready is high only while the sequencer is idle, so one item is in
//   work at a time. A boundary edge takes longer the more of its ends see
//   outflow, and a finalize waits on the serial divider for each of its
//   two components that needs it.
//   Every product goes through the one shared 33x33 multiplier, and every
//   sum update is a read-modify-write on a single-address node memory.
//   Only finalize produces a result, held in an output register; the next
//   item is accepted while it waits. If the receiver stalls, a following
//   finalize holds in its emit step until the register frees up.
//   cfg_data (time step, unsigned Q16.16) is written on a cfg transfer;
//   cfg_ready is always high. Write it only while the block is idle.
//   Reset sets time step to 1.0 and empties the output register. Node
//   memories are not cleared: a node must be loaded before edges or
//   finalize touch it. Indexes at or above NODE_COUNT read as zero and
//   their writes are dropped.
// ----------------------------------------------------------------------------
module upwind_edge_flux_accumulator_unit
  import uefa_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_RDA, S_RDB, S_CAPB,
    S_E_M1, S_E_M2, S_E_DOT, S_E_M3, S_E_UN, S_E_M4, S_E_M5, S_E_FV,
    S_B_M1, S_B_M2, S_B_ANY,
    S_L_M1, S_L_M2, S_L_F, S_L_M3, S_L_M4, S_L_DV,
    S_ACC_RD, S_ACC_WR,
    S_F_RD, S_F_CAP, S_F_M1, S_F_M2, S_F_SUM, S_F_CHK, S_F_WAIT, S_EMIT
  } state_t;

  state_t state_r;

  // Node memories.
  logic signed [31:0] mem_u   [NODE_COUNT];
  logic signed [31:0] mem_v   [NODE_COUNT];
  logic [30:0]        mem_vol [NODE_COUNT];
  logic signed [47:0] mem_su  [NODE_COUNT];
  logic signed [47:0] mem_sv  [NODE_COUNT];

  logic signed [31:0] rd_u_r, rd_v_r;
  logic [30:0]        rd_vol_r;
  logic signed [47:0] rd_su_r, rd_sv_r;

  // Item and working registers.
  in_item_t           item_r;
  logic [31:0]        time_step_r;
  logic               ok_a_r, ok_b_r;
  logic               sel_r;
  logic               comp_r;
  logic signed [31:0] ua_r, va_r, ub_r, vb_r;
  logic signed [31:0] u12_r, v12_r;
  logic signed [47:0] t_r;
  logic signed [31:0] dot_r, un_r, anx_r, any_r;
  logic signed [47:0] du_r, dv_r;
  logic signed [47:0] su_r, sv_r;
  logic [30:0]        vol_r;
  logic [63:0]        plo_r;
  logic [47:0]        phi_r;
  logic signed [31:0] res_u_r;
  logic signed [31:0] res_v_r;
  logic signed [65:0] prod_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Shared multiplier and memory port controls.
  logic signed [32:0] mul_a, mul_b;
  logic signed [47:0] mulq;
  logic [AW-1:0]      addr;
  logic               wr_node, wr_sum;
  logic signed [47:0] wsum_u, wsum_v;

  // Derived values.
  logic               ok_a_in, ok_b_in;
  logic signed [31:0] rd_ub, rd_vb;
  logic signed [32:0] sum_u12, sum_v12;
  logic signed [31:0] cur_u, cur_v, up_u, up_v;
  logic               cur_ok;
  logic signed [47:0] cur_s;
  logic               neg;
  logic [47:0]        mag;
  logic signed [31:0] f_val;
  logic signed [31:0] div_res;
  logic               acc_done_next;

  div_req_t           div_req;
  logic               div_busy, div_done;
  logic [31:0]        div_q;

  assign ok_a_in = 32'(in_data.node_a) < NODE_COUNT;
  assign ok_b_in = 32'(in_data.node_b) < NODE_COUNT;

  assign mulq  = prod_r[63:16];
  assign rd_ub = ok_b_r ? rd_u_r : 32'sd0;
  assign rd_vb = ok_b_r ? rd_v_r : 32'sd0;
  assign sum_u12 = {ua_r[31], ua_r} + {rd_ub[31], rd_ub};
  assign sum_v12 = {va_r[31], va_r} + {rd_vb[31], rd_vb};

  assign cur_u  = sel_r ? ub_r : ua_r;
  assign cur_v  = sel_r ? vb_r : va_r;
  assign cur_ok = sel_r ? ok_b_r : ok_a_r;
  assign up_u   = (un_r > 32'sd0) ? ua_r : ub_r;
  assign up_v   = (un_r > 32'sd0) ? va_r : vb_r;
  assign f_val  = sat32(ext48(t_r) + ext48(mulq));

  assign cur_s = comp_r ? sv_r : su_r;
  assign neg   = cur_s[47];
  assign mag   = neg ? 48'(-cur_s) : 48'(cur_s);

  // Quotient to signed Q16.16 with saturation by sign.
  always_comb begin
    if (neg) div_res = (div_q >= 32'h80000000) ? 32'sh80000000 : 32'(-div_q);
    else     div_res = (div_q > 32'h7fffffff) ? 32'sh7fffffff : div_q;
  end

  assign wsum_u = sat48(ext48(rd_su_r) + ext48(du_r));
  assign wsum_v = sat48(ext48(rd_sv_r) + ext48(dv_r));

  // Multiplier operands, memory address and write strobes per step.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    addr    = AW'(item_r.node_a);
    wr_node = 1'b0;
    wr_sum  = 1'b0;
    case (state_r)
      S_LOAD: begin
        wr_node = ok_a_r;
        wr_sum  = ok_a_r;
      end
      S_RDB:    addr = AW'(item_r.node_b);
      S_E_M1: begin
        mul_a = {u12_r[31], u12_r};
        mul_b = {item_r.normal_x[31], item_r.normal_x};
      end
      S_E_M2: begin
        mul_a = {v12_r[31], v12_r};
        mul_b = {item_r.normal_y[31], item_r.normal_y};
      end
      S_E_M3: begin
        mul_a = {dot_r[31], dot_r};
        mul_b = {2'b00, item_r.edge_length};
      end
      S_E_M4: begin
        mul_a = {un_r[31], un_r};
        mul_b = {up_u[31], up_u};
      end
      S_E_M5: begin
        mul_a = {un_r[31], un_r};
        mul_b = {up_v[31], up_v};
      end
      S_B_M1: begin
        mul_a = {item_r.normal_x[31], item_r.normal_x};
        mul_b = {3'b000, item_r.edge_length[30:1]};
      end
      S_B_M2: begin
        mul_a = {item_r.normal_y[31], item_r.normal_y};
        mul_b = {3'b000, item_r.edge_length[30:1]};
      end
      S_L_M1: begin
        mul_a = {cur_u[31], cur_u};
        mul_b = {anx_r[31], anx_r};
      end
      S_L_M2: begin
        mul_a = {cur_v[31], cur_v};
        mul_b = {any_r[31], any_r};
      end
      S_L_M3: begin
        mul_a = {cur_u[31], cur_u};
        mul_b = {dot_r[31], dot_r};
      end
      S_L_M4: begin
        mul_a = {cur_v[31], cur_v};
        mul_b = {dot_r[31], dot_r};
      end
      S_ACC_RD: addr = sel_r ? AW'(item_r.node_b) : AW'(item_r.node_a);
      S_ACC_WR: begin
        addr   = sel_r ? AW'(item_r.node_b) : AW'(item_r.node_a);
        wr_sum = cur_ok;
      end
      S_F_M1: begin
        mul_a = {1'b0, mag[31:0]};
        mul_b = {1'b0, time_step_r};
      end
      S_F_M2: begin
        mul_a = {17'd0, mag[47:32]};
        mul_b = {1'b0, time_step_r};
      end
      default: ;
    endcase
  end

  // Node memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_node) begin
      mem_u[addr]   <= item_r.vel_u;
      mem_v[addr]   <= item_r.vel_v;
      mem_vol[addr] <= item_r.volume;
    end
    if (wr_sum) begin
      mem_su[addr] <= (state_r == S_LOAD) ? 48'sd0 : wsum_u;
      mem_sv[addr] <= (state_r == S_LOAD) ? 48'sd0 : wsum_v;
    end
    rd_u_r   <= mem_u[addr];
    rd_v_r   <= mem_v[addr];
    rd_vol_r <= mem_vol[addr];
    rd_su_r  <= mem_su[addr];
    rd_sv_r  <= mem_sv[addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign div_req.start   = (state_r == S_F_CHK) && ok_a_r && (mag != 48'd0) &&
                           (phi_r < {17'd0, vol_r});
  assign div_req.divisor = vol_r;
  assign div_req.rem     = phi_r[30:0];
  assign div_req.low     = plo_r[31:0];

  uefa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // After a sum update, either move to the other end or finish.
  assign acc_done_next = sel_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      time_step_r <= TIME_STEP_RESET;
    end else begin
      if (cfg_valid) time_step_r <= cfg_data;
      // The emit step handles the output register itself.
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            ok_a_r <= ok_a_in;
            ok_b_r <= ok_b_in;
            sel_r  <= 1'b0;
            comp_r <= 1'b0;
            case (in_data.kind)
              KIND_LOAD:  state_r <= S_LOAD;
              KIND_FINAL: state_r <= S_F_RD;
              default:    state_r <= S_RDA;
            endcase
          end
        end
        S_LOAD: state_r <= S_IDLE;
        S_RDA:  state_r <= S_RDB;
        S_RDB: begin
          ua_r    <= ok_a_r ? rd_u_r : 32'sd0;
          va_r    <= ok_a_r ? rd_v_r : 32'sd0;
          state_r <= S_CAPB;
        end
        S_CAPB: begin
          ub_r  <= rd_ub;
          vb_r  <= rd_vb;
          u12_r <= sum_u12[32:1];
          v12_r <= sum_v12[32:1];
          state_r <= (item_r.kind == KIND_INTERIOR) ? S_E_M1 : S_B_M1;
        end
        S_E_M1: state_r <= S_E_M2;
        S_E_M2: begin
          t_r     <= mulq;
          state_r <= S_E_DOT;
        end
        S_E_DOT: begin
          dot_r   <= f_val;
          state_r <= S_E_M3;
        end
        S_E_M3: state_r <= S_E_UN;
        S_E_UN: begin
          un_r    <= sat32(ext48(mulq));
          state_r <= S_E_M4;
        end
        S_E_M4: state_r <= S_E_M5;
        S_E_M5: begin
          du_r    <= -mulq;
          state_r <= S_E_FV;
        end
        S_E_FV: begin
          dv_r    <= -mulq;
          state_r <= S_ACC_RD;
        end
        S_B_M1: state_r <= S_B_M2;
        S_B_M2: begin
          anx_r   <= sat32(ext48(mulq));
          state_r <= S_B_ANY;
        end
        S_B_ANY: begin
          any_r   <= sat32(ext48(mulq));
          state_r <= S_L_M1;
        end
        S_L_M1: state_r <= S_L_M2;
        S_L_M2: begin
          t_r     <= mulq;
          state_r <= S_L_F;
        end
        S_L_F: begin
          dot_r <= f_val;
          // Only outflow through the edge costs anything.
          if (f_val > 32'sd0) begin
            state_r <= S_L_M3;
          end else if (!sel_r) begin
            sel_r   <= 1'b1;
            state_r <= S_L_M1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_L_M3: state_r <= S_L_M4;
        S_L_M4: begin
          du_r    <= -mulq;
          state_r <= S_L_DV;
        end
        S_L_DV: begin
          dv_r    <= -mulq;
          state_r <= S_ACC_RD;
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          if (acc_done_next) begin
            state_r <= S_IDLE;
          end else if (item_r.kind == KIND_INTERIOR) begin
            // The flux leaving node_a enters node_b.
            du_r    <= -du_r;
            dv_r    <= -dv_r;
            sel_r   <= 1'b1;
            state_r <= S_ACC_RD;
          end else begin
            sel_r   <= 1'b1;
            state_r <= S_L_M1;
          end
        end
        S_F_RD: state_r <= S_F_CAP;
        S_F_CAP: begin
          su_r    <= rd_su_r;
          sv_r    <= rd_sv_r;
          vol_r   <= rd_vol_r;
          state_r <= S_F_M1;
        end
        S_F_M1: state_r <= S_F_M2;
        S_F_M2: begin
          plo_r   <= prod_r[63:0];
          state_r <= S_F_SUM;
        end
        S_F_SUM: begin
          phi_r   <= prod_r[47:0] + {16'd0, plo_r[63:32]};
          state_r <= S_F_CHK;
        end
        S_F_CHK: begin
          if (!ok_a_r || mag == 48'd0) begin
            if (comp_r) res_v_r <= 32'sd0;
            else        res_u_r <= 32'sd0;
            comp_r  <= 1'b1;
            state_r <= comp_r ? S_EMIT : S_F_M1;
          end else if (phi_r >= {17'd0, vol_r}) begin
            // Quotient reaches 2^32 (also the zero volume case).
            if (comp_r) res_v_r <= neg ? 32'sh80000000 : 32'sh7fffffff;
            else        res_u_r <= neg ? 32'sh80000000 : 32'sh7fffffff;
            comp_r  <= 1'b1;
            state_r <= comp_r ? S_EMIT : S_F_M1;
          end else begin
            state_r <= S_F_WAIT;
          end
        end
        S_F_WAIT: begin
          if (div_done) begin
            if (!comp_r) res_u_r <= div_res;
            else res_v_r <= div_res;
            comp_r  <= 1'b1;
            state_r <= comp_r ? S_EMIT : S_F_M1;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_data_r.out_node <= item_r.node_a;
            out_data_r.rhs_u    <= res_u_r;
            out_data_r.rhs_v    <= res_v_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A finalize transfer always occupies the sequencer on the next cycle.
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == KIND_FINAL |=> !in_ready)
    else $error("finalize did not hold off the input channel");

  // The divider is started only when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  // The divider is never left running while the block is idle.
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_busy)
    else $error("divider busy in idle");
`endif

endmodule

// File: bench/uefa_flux_checker.sv
// ----------------------------------------------------------------------------
// uefa_flux_checker: result checker for the upwind edge flux accumulator
// Watches the item, result and time step channels. It keeps its own copy of
// the node store, works out each finalize result and compares it field by
// field with what the block delivers.
// ----------------------------------------------------------------------------
module uefa_flux_checker
  import uefa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  localparam longint LIM32_HI = 64'sd2147483647;
  localparam longint LIM32_LO = -64'sd2147483648;
  localparam longint LIM48_HI = 64'sd140737488355327;
  localparam longint LIM48_LO = -64'sd140737488355328;

  logic [31:0] step_q = TIME_STEP_RESET;
  longint      vel_u_mem [NODE_COUNT_DEF];
  longint      vel_v_mem [NODE_COUNT_DEF];
  longint      vol_mem   [NODE_COUNT_DEF];
  longint      acc_u_mem [NODE_COUNT_DEF];
  longint      acc_v_mem [NODE_COUNT_DEF];
  out_item_t   rhs_expected [$];

  initial begin
    fail_count   = 0;
    results_seen = 0;
  end

  assign pending = rhs_expected.size();

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Q16.16 product, floored.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic void add_flux(input int n, input longint du, input longint dv);
    acc_u_mem[n] = clip(acc_u_mem[n] + du, LIM48_LO, LIM48_HI);
    acc_v_mem[n] = clip(acc_v_mem[n] + dv, LIM48_LO, LIM48_HI);
  endfunction

  // Outflow loss at one end of a boundary edge, only where flux leaves.
  function automatic void outflow_loss(input int n, input longint anx, input longint any_);
    longint f;
    f = clip(qmul(vel_u_mem[n], anx) + qmul(vel_v_mem[n], any_), LIM32_LO, LIM32_HI);
    if (f > 0) add_flux(n, -qmul(vel_u_mem[n], f), -qmul(vel_v_mem[n], f));
  endfunction

  // Sum times time step over volume, truncated toward zero and saturated.
  function automatic logic signed [31:0] scaled_rhs(input longint s, input longint vol);
    logic         neg;
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] quo;
    if (s == 0) return 32'sd0;
    neg = (s < 0);
    if (vol == 0) return neg ? 32'sh80000000 : 32'sh7fffffff;
    mag  = neg ? 64'(-s) : 64'(s);
    prod = 128'(mag) * 128'(step_q);
    quo  = prod / 128'(vol);
    if (neg) return (quo >= 128'h8000_0000) ? 32'sh80000000 : 32'(-quo);
    return (quo > 128'h7fff_ffff) ? 32'sh7fffffff : 32'(quo);
  endfunction

  function automatic void predict(input in_item_t it);
    int        a;
    int        b;
    int        up;
    longint    u12;
    longint    v12;
    longint    dot;
    longint    un;
    longint    fu;
    longint    fv;
    longint    h;
    longint    anx;
    longint    any_;
    out_item_t r;
    a = it.node_a;
    b = it.node_b;
    case (it.kind)
      KIND_LOAD: begin
        vel_u_mem[a] = longint'(it.vel_u);
        vel_v_mem[a] = longint'(it.vel_v);
        vol_mem[a]   = longint'(it.volume);
        acc_u_mem[a] = 0;
        acc_v_mem[a] = 0;
      end
      KIND_INTERIOR: begin
        u12 = (vel_u_mem[a] + vel_u_mem[b]) >>> 1;
        v12 = (vel_v_mem[a] + vel_v_mem[b]) >>> 1;
        dot = clip(qmul(u12, longint'(it.normal_x)) + qmul(v12, longint'(it.normal_y)),
                   LIM32_LO, LIM32_HI);
        un  = clip(qmul(dot, longint'(it.edge_length)), LIM32_LO, LIM32_HI);
        up  = (un > 0) ? a : b;
        fu  = qmul(un, vel_u_mem[up]);
        fv  = qmul(un, vel_v_mem[up]);
        add_flux(a, -fu, -fv);
        add_flux(b, fu, fv);
      end
      KIND_BOUNDARY: begin
        h    = longint'(it.edge_length) >>> 1;
        anx  = clip(qmul(longint'(it.normal_x), h), LIM32_LO, LIM32_HI);
        any_ = clip(qmul(longint'(it.normal_y), h), LIM32_LO, LIM32_HI);
        outflow_loss(a, anx, any_);
        outflow_loss(b, anx, any_);
      end
      default: begin
        r.out_node = it.node_a;
        r.rhs_u    = scaled_rhs(acc_u_mem[a], vol_mem[a]);
        r.rhs_v    = scaled_rhs(acc_v_mem[a], vol_mem[a]);
        rhs_expected.push_back(r);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) step_q <= cfg_data;
      if (in_valid && in_ready) predict(in_data);
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (rhs_expected.size() == 0) begin
          $error("unexpected result transfer: node %0d", out_data.out_node);
          fail_count <= fail_count + 1;
        end else begin
          automatic out_item_t e = rhs_expected.pop_front();
          automatic int bad = 0;
          if (out_data.out_node !== e.out_node) begin
            $error("out_node: expected %0d, got %0d", e.out_node, out_data.out_node);
            bad++;
          end
          if (out_data.rhs_u !== e.rhs_u) begin
            $error("rhs_u: expected %0d, got %0d", e.rhs_u, out_data.rhs_u);
            bad++;
          end
          if (out_data.rhs_v !== e.rhs_v) begin
            $error("rhs_v: expected %0d, got %0d", e.rhs_v, out_data.rhs_v);
            bad++;
          end
          fail_count <= fail_count + bad;
        end
      end
    end
  end

endmodule

// File: bench/tb_upwind_edge_flux_accumulator_unit.sv
// ----------------------------------------------------------------------------
// tb_upwind_edge_flux_accumulator_unit: testbench of the flux accumulator
// Drives directed and random node, edge and finalize items under random
// idling on both sides, across several time step settings, and lets the
// checker predict and compare every finalize result.
// ----------------------------------------------------------------------------
module tb_upwind_edge_flux_accumulator_unit;
  import uefa_pkg::*;

  // The cycle cap leaves a wide margin over a run of all the items with their
  // gaps and stalls.
  localparam int CYCLE_CAP  = 1500000;
  localparam int DRAIN_WAIT = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  int   fail_count;
  int   pending;
  int   results_seen;
  int   items_sent = 0;
  int   cycles = 0;
  int   stall_left = 0;
  logic calm = 1'b0;
  logic in_fire_q = 1'b0;
  logic cfg_fire_q = 1'b0;

  // Nodes that have been loaded; edges and finalize touch only these.
  logic loaded_map [NODE_COUNT_DEF];
  int   loaded_nodes [$];

  upwind_edge_flux_accumulator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  uefa_flux_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Transfers are recorded at the rising edge so that the driving code,
  // which runs on the falling edge, sees a settled value.
  always @(posedge clk) begin
    in_fire_q  <= in_valid && in_ready;
    cfg_fire_q <= cfg_valid && cfg_ready;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_upwind_edge_flux_accumulator_unit NOT OK");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the calm tail of the
  // run.
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Signed Q16.16 value: mostly moderate magnitudes so that sums build up
  // without saturating at once, plus the extremes and fully random words.
  function automatic logic [31:0] pick_q32();
    logic [31:0] m;
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h0;
      default: begin
        m = $urandom_range(0, 32'h3_ffff);
        return $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  function automatic logic [30:0] pick_q31(input logic nonzero);
    logic [30:0] m;
    case ($urandom_range(0, 5))
      0: m = 31'($urandom);
      1: m = 31'h7fff_ffff;
      2: m = 31'd1;
      default: m = 31'($urandom_range(0, 32'h3_ffff));
    endcase
    if (nonzero && m == 0) m = 31'd1;
    return m;
  endfunction

  function automatic int any_loaded();
    return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
  endfunction

  function automatic in_item_t make_load(input int n);
    in_item_t it;
    it        = '0;
    it.kind   = KIND_LOAD;
    it.node_a = 10'(n);
    it.node_b = 10'($urandom);
    it.vel_u  = pick_q32();
    it.vel_v  = pick_q32();
    it.volume = pick_q31(1'b1);
    return it;
  endfunction

  function automatic in_item_t make_edge(input kind_t k);
    in_item_t it;
    it             = '0;
    it.kind        = k;
    it.node_a      = 10'(any_loaded());
    it.node_b      = ($urandom_range(0, 15) == 0) ? it.node_a : 10'(any_loaded());
    it.vel_u       = $urandom;
    it.vel_v       = $urandom;
    it.normal_x    = pick_q32();
    it.normal_y    = pick_q32();
    it.edge_length = pick_q31(1'b0);
    it.volume      = 31'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_final();
    in_item_t it;
    it        = '0;
    it.kind   = KIND_FINAL;
    it.node_a = 10'(any_loaded());
    it.node_b = 10'($urandom);
    return it;
  endfunction

  // Hands one item to the block, with an optional idle burst before it.
  task automatic send(input in_item_t it);
    if (it.kind == KIND_LOAD && !loaded_map[it.node_a]) begin
      loaded_map[it.node_a] = 1'b1;
      loaded_nodes.push_back(it.node_a);
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_fire_q);
    items_sent++;
  endtask

  task automatic send_load(input int n, input logic [31:0] u, input logic [31:0] v,
                           input logic [30:0] vol);
    in_item_t it;
    it        = '0;
    it.kind   = KIND_LOAD;
    it.node_a = 10'(n);
    it.vel_u  = u;
    it.vel_v  = v;
    it.volume = vol;
    send(it);
  endtask

  task automatic send_edge(input kind_t k, input int a, input int b, input logic [31:0] nx,
                           input logic [31:0] ny, input logic [30:0] len);
    in_item_t it;
    it             = '0;
    it.kind        = k;
    it.node_a      = 10'(a);
    it.node_b      = 10'(b);
    it.normal_x    = nx;
    it.normal_y    = ny;
    it.edge_length = len;
    send(it);
  endtask

  task automatic send_final(input int n);
    in_item_t it;
    it        = '0;
    it.kind   = KIND_FINAL;
    it.node_a = 10'(n);
    send(it);
  endtask

  // The time step is only changed once every result is back and the block
  // has had time to finish an edge item that produces no result.
  task automatic write_time_step(input logic [31:0] value);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(negedge clk); while (!cfg_fire_q);
    cfg_valid = 1'b0;
  endtask

  task automatic random_items(input int count, input int calm_from);
    int       roll;
    int       n;
    for (int i = 0; i < count; i++) begin
      if (i == calm_from) calm = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
        // Loads mostly land on a small set of nodes so that edges overlap.
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                        : $urandom_range(0, 23) * 41;
        send(make_load(n));
      end else if (roll < 55) begin
        send(make_edge(KIND_INTERIOR));
      end else if (roll < 80) begin
        send(make_edge(KIND_BOUNDARY));
      end else begin
        send(make_final());
      end
    end
  endtask

  initial begin
    foreach (loaded_map[i]) loaded_map[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, run with the reset time step: extreme velocities,
    // volumes and node indexes, both edge kinds with extreme normals and
    // lengths, an edge with the same node at both ends, and a reload that
    // clears a node's sums before it is finalized again.
    send_load(0, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_load(1023, 32'h8000_0000, 32'h7fff_ffff, 31'd1);
    send_load(5, 32'h0001_0000, 32'hfffe_0000, 31'h0001_0000);
    send_load(6, 32'h0, 32'h0000_8000, 31'h0000_4000);
    send_edge(KIND_INTERIOR, 0, 1023, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_edge(KIND_INTERIOR, 5, 6, 32'h0001_0000, 32'h0, 31'h0001_0000);
    send_edge(KIND_INTERIOR, 6, 5, 32'hffff_0000, 32'h0, 31'h0002_0000);
    send_edge(KIND_INTERIOR, 5, 5, 32'h0001_0000, 32'h0001_0000, 31'h0001_0000);
    send_edge(KIND_BOUNDARY, 0, 1023, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send_edge(KIND_BOUNDARY, 5, 5, 32'h0001_0000, 32'h0, 31'h0002_0000);
    send_edge(KIND_BOUNDARY, 6, 5, 32'h0, 32'h8000_0000, 31'h0003_0000);
    send_edge(KIND_BOUNDARY, 1023, 0, 32'h8000_0000, 32'h0, 31'h0);
    send_final(0);
    send_final(1023);
    send_final(5);
    send_final(6);
    send_load(5, 32'h0002_0000, 32'h0003_0000, 31'h0001_0000);
    send_final(5);

    // Random part over several time step settings, the extremes among them.
    write_time_step(32'h0000_8000);
    random_items(470, -1);
    write_time_step(32'hffff_ffff);
    random_items(470, -1);
    write_time_step(32'h0);
    random_items(470, -1);
    write_time_step($urandom);
    random_items(470, 270);

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d items (loads, interior and boundary edges, finalizes) under",
             items_sent);
    $display("five time step settings; %0d finalize results were compared.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_upwind_edge_flux_accumulator_unit OK");
    end else begin
      $display("tb_upwind_edge_flux_accumulator_unit NOT OK");
    end
    $finish;
  end

endmodule
